### hdl/fpll_pkg.sv
// fpll_pkg: shared constants, register codes and control structs of the data separator
`timescale 1ns / 1ps

package fpll_pkg;

  // default module parameters
  localparam int FRAC_BITS_DEF      = 8;
  localparam int MAX_CELLS_DEF      = 64;
  localparam int INTERVAL_WIDTH_DEF = 16;

  // fixed field widths
  localparam int CP_W        = 24;  // clock period and its bounds
  localparam int GAIN_W      = 16;  // Q0.16 gains, Q4.12 scale
  localparam int CFG_W       = 24;  // widest register
  localparam int CFG_IDX_W   = 3;
  localparam int ZR_W        = 3;
  localparam int GOOD_W      = 9;
  localparam int SCALE_FRAC  = 12;  // fraction bits of the interval scale factor

  localparam int DAMP_ONE    = 1 << GAIN_W;  // 1.0 in Q0.16
  localparam int ZR_SAT      = 4;
  localparam int ZR_SYNC_MAX = 3;
  localparam int GOOD_SAT    = 256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_CENTRE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_MIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 3'd5;

  // register reset values
  localparam logic [CP_W-1:0]   RST_CLOCK_CENTRE = 24'd12288;
  localparam logic [CP_W-1:0]   RST_CLOCK_MIN    = 24'd11674;
  localparam logic [CP_W-1:0]   RST_CLOCK_MAX    = 24'd12902;
  localparam logic [GAIN_W-1:0] RST_FREQ_GAIN    = 16'd3277;
  localparam logic [GAIN_W-1:0] RST_DAMP_GAIN    = 16'd49152;
  localparam logic [GAIN_W-1:0] RST_SCALE_FACTOR = 16'd4096;

  // controller to datapath
  typedef struct packed {
    logic load;         // latch the accepted interval
    logic scale;        // interval times scale, cell cap
    logic sat;          // shift and saturate the scaled interval
    logic add;          // add to the phase, start the run
    logic push;         // move the pending bit to the output register
    logic clear_phase;  // run hit the cell cap
    logic cell_step;    // subtract one clock, classify the cell
    logic mul;          // pll products
    logic adj;          // clock correction sum, phase damping
    logic clamp;        // clamp the clock, finish the 1 cell
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cont;        // phase is at least half a clock
    logic n_full;      // cell cap reached
    logic is_zero;     // cell under subtraction is a 0
    logic pend_valid;  // a finished bit waits for its last flag
    logic out_free;    // output register can take an item
  } status_t;

endpackage

### hdl/fpll_channels.sv
// fpll channel interfaces: flux interval input and decoded bit output
`timescale 1ns / 1ps

interface fpll_interval_if #(
  parameter int W = fpll_pkg::INTERVAL_WIDTH_DEF
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] interval_ticks;

  modport source (output valid, output interval_ticks, input ready);
  modport sink   (input valid, input interval_ticks, output ready);
endinterface

interface fpll_bit_if ();
  logic valid;
  logic ready;
  logic bit_value;
  logic last;
  logic sync_lost;

  modport source (output valid, output bit_value, output last, output sync_lost, input ready);
  modport sink   (input valid, input bit_value, input last, input sync_lost, output ready);
endinterface

### hdl/fpll_ctrl.sv
// fpll_ctrl: sequencer for one interval's run of bit cells
`timescale 1ns / 1ps

module fpll_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fpll_pkg::status_t st,
  output fpll_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SAT,
    ST_ADD,
    ST_TEST,
    ST_CELL,
    ST_MUL,
    ST_ADJ,
    ST_CLAMP
  } state_t;

  state_t state;
  state_t state_next;
  logic   test_go;
  logic   more;

  assign in_ready = (state == ST_IDLE);
  // test can proceed once any pending bit has a place to go
  assign test_go  = !st.pend_valid || st.out_free;
  assign more     = st.cont && !st.n_full;

  // command decode
  always_comb begin
    cmd             = '0;
    cmd.load        = in_valid && in_ready;
    cmd.scale       = (state == ST_SCALE);
    cmd.sat         = (state == ST_SAT);
    cmd.add         = (state == ST_ADD);
    cmd.push        = (state == ST_TEST) && st.pend_valid && st.out_free;
    cmd.clear_phase = (state == ST_TEST) && test_go && st.cont && st.n_full;
    cmd.cell_step   = (state == ST_CELL);
    cmd.mul         = (state == ST_MUL);
    cmd.adj         = (state == ST_ADJ);
    cmd.clamp       = (state == ST_CLAMP);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_SAT;
      ST_SAT:   state_next = ST_ADD;
      ST_ADD:   state_next = ST_TEST;
      ST_TEST: begin
        if (test_go) state_next = more ? ST_CELL : ST_IDLE;
      end
      ST_CELL:  state_next = st.is_zero ? ST_TEST : ST_MUL;
      ST_MUL:   state_next = ST_ADJ;
      ST_ADJ:   state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_TEST;
      default:  state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/fpll_datapath.sv
// fpll_datapath: registers, phase accumulator, pll arithmetic and output register
`timescale 1ns / 1ps

module fpll_datapath #(
  parameter int FRAC_BITS      = fpll_pkg::FRAC_BITS_DEF,
  parameter int MAX_CELLS      = fpll_pkg::MAX_CELLS_DEF,
  parameter int INTERVAL_WIDTH = fpll_pkg::INTERVAL_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fpll_pkg::cmd_t                 cmd,
  output fpll_pkg::status_t              st,
  input  logic [INTERVAL_WIDTH-1:0]      in_ticks,
  input  logic                           cfg_we,
  input  logic [fpll_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpll_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_bit,
  output logic                           out_last,
  output logic                           out_lost
);

  localparam int CP_W    = fpll_pkg::CP_W;
  localparam int GAIN_W  = fpll_pkg::GAIN_W;
  localparam int MC_W    = $clog2(MAX_CELLS);
  localparam int CAP_W   = CP_W + MC_W;
  localparam int PH_W    = CAP_W + 2;
  localparam int N_W     = $clog2(MAX_CELLS + 1);
  localparam int PRD_W   = INTERVAL_WIDTH + GAIN_W;
  localparam int SW      = PRD_W + FRAC_BITS;
  localparam int CMP_W   = (SW > CAP_W) ? SW : CAP_W;
  localparam int MI_W    = CP_W + 1;
  localparam int CORR_W  = MI_W + GAIN_W + 1;
  localparam int DAMP_W  = MI_W + GAIN_W + 2;
  localparam int SUM_W   = CP_W + 3;

  // configuration registers
  logic [CP_W-1:0]   clock_centre;
  logic [CP_W-1:0]   clock_min;
  logic [CP_W-1:0]   clock_max;
  logic [GAIN_W-1:0] freq_gain;
  logic [GAIN_W-1:0] damp_gain;
  logic [GAIN_W-1:0] scale_factor;

  // loop state
  logic [CP_W-1:0]                     clock_period;
  logic signed [PH_W-1:0]              phase_accum;
  logic [fpll_pkg::ZR_W-1:0]           zero_run;
  logic [fpll_pkg::GOOD_W-1:0]         good_bit_count;
  logic [N_W-1:0]                      cell_count;
  logic                                pend_valid;
  logic                                pend_bit;
  logic                                pend_lost;

  // working registers
  logic [INTERVAL_WIDTH-1:0]  ticks;
  logic [PRD_W-1:0]           prod;
  logic [CAP_W-1:0]           cap;
  logic [CAP_W-1:0]           scaled;
  logic signed [CORR_W-1:0]   prod_corr;
  logic signed [DAMP_W-1:0]   prod_damp;
  logic signed [SUM_W-1:0]    cp_sum;

  // combinational helpers
  logic [SW-1:0]              sc_wide;
  logic [CMP_W-1:0]           sc_cmp;
  logic [CMP_W-1:0]           cap_cmp;
  logic signed [PH_W+1:0]     cp_ext;
  logic signed [PH_W+1:0]     ph2;
  logic signed [PH_W+1:0]     dph;
  logic signed [PH_W+1:0]     dph2;
  logic signed [MI_W-1:0]     phase_s;
  logic signed [MI_W-1:0]     centre_diff;
  logic signed [MI_W-1:0]     corr_src;
  logic signed [GAIN_W:0]     adj_s;
  logic [GAIN_W:0]            damp_k;
  logic signed [GAIN_W+1:0]   damp_s;
  logic                       in_sync;
  logic signed [CORR_W-1:0]   corr_sh;
  logic [DAMP_W-1:0]          damp_bias;
  logic signed [DAMP_W-1:0]   damp_rt;
  logic signed [DAMP_W-1:0]   damp_sh;
  logic signed [SUM_W-1:0]    min_s;
  logic signed [SUM_W-1:0]    max_s;
  logic signed [SUM_W-1:0]    lo_clip;
  logic signed [SUM_W-1:0]    hi_clip;
  logic [fpll_pkg::GOOD_W-1:0] good_inc;

  // scaled interval, shifted into clock units and limited to the cell cap
  assign sc_wide = (SW'(prod) << FRAC_BITS) >> fpll_pkg::SCALE_FRAC;
  assign sc_cmp  = CMP_W'(sc_wide);
  assign cap_cmp = CMP_W'(cap);

  // half-clock tests: on the phase, and on the phase less one clock
  assign cp_ext = $signed((PH_W + 2)'(clock_period));
  assign ph2    = (PH_W + 2)'(phase_accum) <<< 1;
  assign dph    = (PH_W + 2)'(phase_accum) - cp_ext;
  assign dph2   = dph <<< 1;

  // pll operands; the phase after a 1 is within half a clock
  assign phase_s     = $signed(phase_accum[MI_W-1:0]);
  assign centre_diff = $signed(MI_W'(clock_centre)) - $signed(MI_W'(clock_period));
  assign in_sync     = (zero_run <= fpll_pkg::ZR_W'(fpll_pkg::ZR_SYNC_MAX));
  assign corr_src    = in_sync ? phase_s : centre_diff;
  assign adj_s       = $signed({1'b0, freq_gain});
  assign damp_k      = (GAIN_W + 1)'(fpll_pkg::DAMP_ONE) - (GAIN_W + 1)'(damp_gain);
  assign damp_s      = $signed({1'b0, damp_k});

  // floor for the correction, toward zero for the damping
  assign corr_sh   = prod_corr >>> GAIN_W;
  assign damp_bias = prod_damp[DAMP_W-1] ? DAMP_W'(fpll_pkg::DAMP_ONE - 1) : '0;
  assign damp_rt   = prod_damp + $signed(damp_bias);
  assign damp_sh   = damp_rt >>> GAIN_W;

  // clamp, min first then max
  assign min_s   = $signed(SUM_W'(clock_min));
  assign max_s   = $signed(SUM_W'(clock_max));
  assign lo_clip = (cp_sum < min_s) ? min_s : cp_sum;
  assign hi_clip = (lo_clip > max_s) ? max_s : lo_clip;

  assign good_inc = (good_bit_count < fpll_pkg::GOOD_W'(fpll_pkg::GOOD_SAT)) ?
                    good_bit_count + 1'b1 : good_bit_count;

  // status
  assign st.cont       = (ph2 >= cp_ext);
  assign st.n_full     = (cell_count == N_W'(MAX_CELLS));
  assign st.is_zero    = (dph2 >= cp_ext);
  assign st.pend_valid = pend_valid;
  assign st.out_free   = !out_valid || out_ready;

  // arithmetic working registers
  always_ff @(posedge clk) begin
    if (cmd.load) ticks <= in_ticks;
    if (cmd.scale) begin
      prod <= PRD_W'(ticks) * PRD_W'(scale_factor);
      cap  <= CAP_W'(clock_period) * CAP_W'(MAX_CELLS - 1);
    end
    if (cmd.sat) scaled <= (sc_cmp > cap_cmp) ? cap : CAP_W'(sc_cmp);
    if (cmd.mul) begin
      prod_corr <= CORR_W'(corr_src) * CORR_W'(adj_s);
      prod_damp <= DAMP_W'(phase_s) * DAMP_W'(damp_s);
    end
    if (cmd.adj) cp_sum <= $signed(SUM_W'(clock_period)) + SUM_W'(corr_sh);
  end

  // pending bit payload
  always_ff @(posedge clk) begin
    if (cmd.cell_step && st.is_zero) begin
      pend_bit  <= 1'b0;
      pend_lost <= 1'b0;
    end
    if (cmd.mul) begin
      pend_bit  <= 1'b1;
      pend_lost <= !in_sync && (good_bit_count >= fpll_pkg::GOOD_W'(fpll_pkg::GOOD_SAT));
    end
  end

  // loop state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_centre   <= fpll_pkg::RST_CLOCK_CENTRE;
      clock_min      <= fpll_pkg::RST_CLOCK_MIN;
      clock_max      <= fpll_pkg::RST_CLOCK_MAX;
      freq_gain      <= fpll_pkg::RST_FREQ_GAIN;
      damp_gain      <= fpll_pkg::RST_DAMP_GAIN;
      scale_factor   <= fpll_pkg::RST_SCALE_FACTOR;
      clock_period   <= fpll_pkg::RST_CLOCK_CENTRE;
      phase_accum    <= '0;
      zero_run       <= '0;
      good_bit_count <= '0;
      cell_count     <= '0;
      pend_valid     <= 1'b0;
    end else begin
      // start of a run
      if (cmd.add) begin
        phase_accum <= phase_accum + $signed(PH_W'(scaled));
        zero_run    <= '0;
        cell_count  <= '0;
        pend_valid  <= 1'b0;
      end
      if (cmd.push) pend_valid <= 1'b0;
      if (cmd.clear_phase) phase_accum <= '0;
      // one clock subtracted; a 0 cell finishes here
      if (cmd.cell_step) begin
        phase_accum <= PH_W'(dph);
        if (st.is_zero) begin
          if (zero_run < fpll_pkg::ZR_W'(fpll_pkg::ZR_SAT)) zero_run <= zero_run + 1'b1;
          good_bit_count <= good_inc;
          cell_count     <= cell_count + 1'b1;
          pend_valid     <= 1'b1;
        end
      end
      // a 1 cell: good count restarts on sync loss
      if (cmd.mul) begin
        good_bit_count <= in_sync ? good_inc : fpll_pkg::GOOD_W'(1);
      end
      if (cmd.adj) phase_accum <= PH_W'(damp_sh);
      if (cmd.clamp) begin
        clock_period <= CP_W'(hi_clip);
        cell_count   <= cell_count + 1'b1;
        pend_valid   <= 1'b1;
      end
      // register writes must arrive only while idle; the block does not enforce it
      if (cfg_we) begin
        case (cfg_index)
          fpll_pkg::CFG_CLOCK_CENTRE: begin
            clock_centre <= cfg_data;
            clock_period <= cfg_data;
          end
          fpll_pkg::CFG_CLOCK_MIN:    clock_min    <= cfg_data;
          fpll_pkg::CFG_CLOCK_MAX:    clock_max    <= cfg_data;
          fpll_pkg::CFG_FREQ_GAIN:    freq_gain    <= cfg_data[GAIN_W-1:0];
          fpll_pkg::CFG_DAMP_GAIN:    damp_gain    <= cfg_data[GAIN_W-1:0];
          fpll_pkg::CFG_SCALE_FACTOR: scale_factor <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // output register; last is known once the next half-clock test is done
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_bit  <= pend_bit;
      out_last <= !(st.cont && !st.n_full);
      out_lost <= pend_lost;
    end
  end

endmodule

### hdl/flux_pll_data_separator.sv
// flux_pll_data_separator: top level of the digital pll data separator
`timescale 1ns / 1ps

// Each accepted flux interval is scaled into clock units and added to the
// phase accumulator, then bit cells are clocked out one at a time on the
// bits channel, the final one of the interval marked last; an interval too
// short to reach half a clock yields no item. An interval goes through setup
// (scale, saturate, add, first half-clock test), then each 0 cell takes a
// subtract and a test, and each 1 cell a subtract, the pll multiply stage,
// correction and damping, clamp and a test; a test waits while a finished
// bit cannot enter the output register because the bits channel stalls.
// The datapath has a single subtract/compare path and one multiply stage.
// After a run the block returns to idle, where the next interval is taken.
// A new interval is taken only when the previous one's run is complete,
// while its last item may still wait in the output register. Registers are
// written through cfg_we, cfg_index and cfg_data while no interval is in
// progress (the user must keep to this; the block does not enforce it);
// writing clock_centre also reloads the working clock period.

module flux_pll_data_separator #(
  parameter int FRAC_BITS      = fpll_pkg::FRAC_BITS_DEF,
  parameter int MAX_CELLS      = fpll_pkg::MAX_CELLS_DEF,
  parameter int INTERVAL_WIDTH = fpll_pkg::INTERVAL_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  fpll_interval_if.sink                  intervals,
  fpll_bit_if.source                     bits,
  input  logic                           cfg_we,
  input  logic [fpll_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpll_pkg::CFG_W-1:0]     cfg_data
);

  fpll_pkg::cmd_t    cmd;
  fpll_pkg::status_t st;

  // sequencer
  fpll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (intervals.valid),
    .in_ready (intervals.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // arithmetic and storage
  fpll_datapath #(
    .FRAC_BITS      (FRAC_BITS),
    .MAX_CELLS      (MAX_CELLS),
    .INTERVAL_WIDTH (INTERVAL_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_ticks  (intervals.interval_ticks),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (bits.ready),
    .out_valid (bits.valid),
    .out_bit   (bits.bit_value),
    .out_last  (bits.last),
    .out_lost  (bits.sync_lost)
  );

endmodule

### hdl/fpll_checker.sv
// fpll_checker: port-level assertions for the data separator, bound to the top level
`timescale 1ns / 1ps

module fpll_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic bit_value,
  input logic last,
  input logic sync_lost
);

  // a stalled item holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bit_value) && $stable(last)
      && $stable(sync_lost))
    else $error("output item changed while stalled");

  // sync loss is only reported on a 1 cell
  a_lost_on_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && sync_lost |-> bit_value)
    else $error("sync loss flagged on a 0 cell");

  // the block is busy for at least the cycle after an interval is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("interval accepted in back-to-back cycles");

  // ready to take an interval right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("not ready after reset");

endmodule

bind flux_pll_data_separator fpll_checker u_fpll_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (intervals.valid),
  .in_ready  (intervals.ready),
  .out_valid (bits.valid),
  .out_ready (bits.ready),
  .bit_value (bits.bit_value),
  .last      (bits.last),
  .sync_lost (bits.sync_lost)
);

### test/tb_flux_pll_data_separator.sv
// testbench for flux_pll_data_separator: interval driver, bit monitor and pll bit predictor
`timescale 1ns / 1ps

module tb_flux_pll_data_separator;

  localparam int TW           = fpll_pkg::INTERVAL_WIDTH_DEF;
  localparam int TICKS_MAX    = (1 << TW) - 1;
  localparam int IDLE_PCT     = 17;
  localparam int STEADY_FROM  = 40;
  localparam int STEADY_TO    = 90;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int QUIET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 200;
  localparam int PRINT_LIMIT  = 40;

  typedef struct packed {
    logic bit_value;
    logic last;
    logic sync_lost;
  } bit_cell_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [fpll_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fpll_pkg::CFG_W-1:0] cfg_data;

  fpll_interval_if #(.W(TW)) intervals_ch ();
  fpll_bit_if bits_ch ();

  flux_pll_data_separator dut (
    .clk       (clk),
    .rst       (rst),
    .intervals (intervals_ch),
    .bits      (bits_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies and pll state of the predictor
  longint reg_centre, reg_min, reg_max, reg_adjust, reg_damp, reg_scale;
  longint clk_period, phase_acc;
  int zeros_run, good_bits;

  logic [TW-1:0] pending[$];
  bit_cell_t expected_cells[$];
  int intervals_queued = 0;
  int intervals_taken = 0;
  int cells_seen = 0;
  int mismatch_count = 0;
  logic in_taken = 1'b0;
  int hold_count = 0;
  logic hold_done = 1'b0;
  int default_probes[$] = '{0, 1, 20, 96, 144, 192, 288, 'h00FF, 'hFFFF, 'h5555,
                            'hAAAA, 'hFF00, 'h0F0F, 47, 49, 72, 120};

  // neither side idles over this stretch of items
  wire steady = (intervals_taken >= STEADY_FROM) && (intervals_taken < STEADY_TO);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at bit %0d: %s got %0d want %0d", cells_seen, what, got, want);
  endtask

  // bits one interval produces, pll state updated as it goes
  function automatic void separate_interval(input logic [TW-1:0] ticks);
    longint scaled, cap, prod;
    int n;
    bit_cell_t c;
    scaled = ((longint'(ticks) * reg_scale) << fpll_pkg::FRAC_BITS_DEF) >>> fpll_pkg::SCALE_FRAC;
    cap = (fpll_pkg::MAX_CELLS_DEF - 1) * clk_period;
    if (scaled > cap) scaled = cap;
    phase_acc += scaled;
    zeros_run = 0;
    n = 0;
    while (2 * phase_acc >= clk_period && n < fpll_pkg::MAX_CELLS_DEF) begin
      phase_acc -= clk_period;
      c = '0;
      if (2 * phase_acc >= clk_period) begin
        if (zeros_run < fpll_pkg::ZR_SAT) zeros_run++;
      end else begin
        c.bit_value = 1'b1;
        if (zeros_run <= fpll_pkg::ZR_SYNC_MAX) begin
          clk_period += (phase_acc * reg_adjust) >>> fpll_pkg::GAIN_W;
        end else begin
          // too many zeros: pull toward centre, flag loss after a good run
          clk_period += ((reg_centre - clk_period) * reg_adjust) >>> fpll_pkg::GAIN_W;
          c.sync_lost = (good_bits >= fpll_pkg::GOOD_SAT);
          good_bits = 0;
        end
        if (clk_period < reg_min) clk_period = reg_min;
        if (clk_period > reg_max) clk_period = reg_max;
        // damping truncates toward zero
        prod = phase_acc * (fpll_pkg::DAMP_ONE - reg_damp);
        phase_acc = (prod < 0) ? -((-prod) >>> fpll_pkg::GAIN_W) : (prod >>> fpll_pkg::GAIN_W);
      end
      if (good_bits < fpll_pkg::GOOD_SAT) good_bits++;
      expected_cells.insert(expected_cells.size(), c);
      n++;
    end
    // cell cap clears what is left over
    if (n >= fpll_pkg::MAX_CELLS_DEF && 2 * phase_acc >= clk_period) phase_acc = 0;
    if (n > 0) expected_cells[expected_cells.size() - 1].last = 1'b1;
  endfunction

  task automatic write_reg(input logic [fpll_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fpll_pkg::CFG_W-1:0] value);
    cfg_index = idx;
    cfg_data = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      fpll_pkg::CFG_CLOCK_CENTRE: begin
        reg_centre = longint'(value);
        clk_period = longint'(value);
      end
      fpll_pkg::CFG_CLOCK_MIN: reg_min = longint'(value);
      fpll_pkg::CFG_CLOCK_MAX: reg_max = longint'(value);
      fpll_pkg::CFG_FREQ_GAIN: reg_adjust = longint'(value[fpll_pkg::GAIN_W-1:0]);
      fpll_pkg::CFG_DAMP_GAIN: reg_damp = longint'(value[fpll_pkg::GAIN_W-1:0]);
      fpll_pkg::CFG_SCALE_FACTOR: reg_scale = longint'(value[fpll_pkg::GAIN_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(input int centre, input int cmin, input int cmax,
                            input int adjust, input int damp, input int scale);
    write_reg(fpll_pkg::CFG_CLOCK_CENTRE, fpll_pkg::CFG_W'(centre));
    write_reg(fpll_pkg::CFG_CLOCK_MIN, fpll_pkg::CFG_W'(cmin));
    write_reg(fpll_pkg::CFG_CLOCK_MAX, fpll_pkg::CFG_W'(cmax));
    write_reg(fpll_pkg::CFG_FREQ_GAIN, fpll_pkg::CFG_W'(adjust));
    write_reg(fpll_pkg::CFG_DAMP_GAIN, fpll_pkg::CFG_W'(damp));
    write_reg(fpll_pkg::CFG_SCALE_FACTOR, fpll_pkg::CFG_W'(scale));
  endtask

  task automatic queue_interval(input int ticks);
    pending.insert(pending.size(), ticks[TW-1:0]);
    intervals_queued++;
  endtask

  // a run of whole cells with some jitter
  function automatic int jittered(input int cell_len, input int cells);
    int j, t;
    j = (cell_len >= 8) ? cell_len / 8 : 1;
    t = cell_len * cells + int'($urandom_range(2 * j)) - j;
    if (t < 0) t = 0;
    if (t > TICKS_MAX) t = TICKS_MAX;
    return t;
  endfunction

  // mostly mfm-like runs of 2 to 4 cells, broken by long gaps and noise
  task automatic queue_random(input int cell_len, input int count, input int first_burst);
    int burst;
    burst = first_burst;
    repeat (count) begin
      if (burst == 0) begin
        burst = $urandom_range(110, 10);
        if ($urandom_range(1) == 1) queue_interval(jittered(cell_len, $urandom_range(12, 5)));
        else queue_interval($urandom_range(TICKS_MAX));
      end else begin
        burst--;
        if ($urandom_range(99) < 4) queue_interval($urandom_range(cell_len / 4));
        else queue_interval(jittered(cell_len, $urandom_range(4, 2)));
      end
    end
  endtask

  // every queued item taken, every bit back, then QUIET_CYCLES more for silent items
  task automatic wait_quiet();
    do @(negedge clk);
    while (intervals_taken != intervals_queued || expected_cells.size() != 0);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // feed full intervals until the phase is no longer negative
  task automatic settle_phase();
    while (phase_acc < 0) begin
      queue_interval(TICKS_MAX);
      wait_quiet();
    end
  endtask

  // interval driver
  always @(negedge clk) begin
    if (rst) begin
      intervals_ch.valid <= 1'b0;
    end else if (!intervals_ch.valid || in_taken) begin
      if (pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        intervals_ch.interval_ticks <= pending.pop_front();
        intervals_ch.valid <= 1'b1;
      end else begin
        intervals_ch.valid <= 1'b0;
      end
    end
  end

  // bit receiver with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      bits_ch.ready <= 1'b0;
    end else if (hold_count != 0) begin
      hold_count <= hold_count - 1;
      bits_ch.ready <= 1'b0;
    end else if (!hold_done && cells_seen >= HOLD_AT) begin
      hold_count <= HOLD_CYCLES;
      hold_done <= 1'b1;
      bits_ch.ready <= 1'b0;
    end else begin
      bits_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: check bits against the oldest expectation, predict on taken intervals
  always @(posedge clk) begin : monitor
    bit_cell_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= intervals_ch.valid && intervals_ch.ready;
      if (bits_ch.valid && bits_ch.ready) begin
        cells_seen++;
        if (expected_cells.size() == 0) begin
          report_mismatch("bit with nothing expected, value", int'(bits_ch.bit_value), 0);
        end else begin
          want = expected_cells.pop_front();
          if (bits_ch.bit_value !== want.bit_value)
            report_mismatch("bit_value", int'(bits_ch.bit_value), int'(want.bit_value));
          if (bits_ch.last !== want.last)
            report_mismatch("last", int'(bits_ch.last), int'(want.last));
          if (bits_ch.sync_lost !== want.sync_lost)
            report_mismatch("sync_lost", int'(bits_ch.sync_lost), int'(want.sync_lost));
        end
      end
      if (intervals_ch.valid && intervals_ch.ready) begin
        intervals_taken++;
        separate_interval(intervals_ch.interval_ticks);
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((intervals_ch.valid && intervals_ch.ready) || (bits_ch.valid && bits_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = fpll_pkg::CFG_CLOCK_CENTRE;
    cfg_data = '0;
    reg_centre = longint'(fpll_pkg::RST_CLOCK_CENTRE);
    reg_min = longint'(fpll_pkg::RST_CLOCK_MIN);
    reg_max = longint'(fpll_pkg::RST_CLOCK_MAX);
    reg_adjust = longint'(fpll_pkg::RST_FREQ_GAIN);
    reg_damp = longint'(fpll_pkg::RST_DAMP_GAIN);
    reg_scale = longint'(fpll_pkg::RST_SCALE_FACTOR);
    clk_period = reg_centre;
    phase_acc = 0;
    zeros_run = 0;
    good_bits = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset values: field extremes, short gaps, long runs, cell cap
    foreach (default_probes[i]) queue_interval(default_probes[i]);
    queue_random(48, 110, 95);
    wait_quiet();

    // clock of one unit, bounds inverted, no correction, full damping
    set_config(1, 24'hFFFFFF, 1, 0, 16'hFFFF, 1);
    settle_phase();
    queue_random(16, 40, 10);
    wait_quiet();

    // inverted bounds without damping: a 1 that shrinks the clock keeps the run going
    set_config(3000, 5000, 2000, 30000, 0, 4096);
    settle_phase();
    queue_interval(16);
    queue_interval(24);
    queue_random(8, 35, 10);
    wait_quiet();

    // widest clock range, full frequency gain, no damping, largest scale
    set_config(24'hFFFFFF, 1, 24'hFFFFFF, 16'hFFFF, 0, 16'hFFFF);
    settle_phase();
    queue_random(4096, 40, 10);
    wait_quiet();

    // zero scale: nothing reaches the phase
    write_reg(fpll_pkg::CFG_SCALE_FACTOR, '0);
    queue_interval(0);
    queue_interval(TICKS_MAX);
    repeat (3) queue_interval($urandom_range(TICKS_MAX));
    wait_quiet();

    // moderate gains at double scale
    set_config(12288, 12000, 12600, 16384, 16384, 8192);
    settle_phase();
    queue_random(24, 40, 10);
    wait_quiet();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
hdl/fpll_pkg.sv
hdl/fpll_channels.sv
hdl/fpll_ctrl.sv
hdl/fpll_datapath.sv
hdl/flux_pll_data_separator.sv
hdl/fpll_checker.sv
test/tb_flux_pll_data_separator.sv
